// ===== rtl/tlatq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlatq_pkg: shared types and constants
// Request kinds, status codes, controller states and the control record
// between the controller and the datapath of the aging task queue.
// ----------------------------------------------------------------------------
package tlatq_pkg;

    localparam int TIMER_BITS = 4;
    localparam int KIND_BITS = 3;
    localparam int STATUS_BITS = 2;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [TIMER_BITS-1:0] URGENT_QUANTUM_RESET = 4'd3;
    localparam logic [TIMER_BITS-1:0] NORMAL_QUANTUM_RESET = 4'd10;

    localparam logic [KIND_BITS-1:0] KIND_ENQ_URGENT = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_ENQ_NORMAL = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_TICK_URGENT = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_TICK_NORMAL = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_DEQUEUE = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_URGENT_QUANTUM = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_QUANTUM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UAGE,
        ST_UEXP,
        ST_UKEEP,
        ST_NSCAN,
        ST_RESULT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request
        logic do_simple;   // enqueue, dequeue or no operation
        logic age_urgent;  // decrement urgent timers
        logic age_normal;  // decrement normal timers
        logic scan_start;  // clear the scan index, and the build counter when aging
        logic uexp_step;   // gather one expired urgent entry
        logic ukeep_step;  // gather one live urgent entry
        logic ucommit;     // copy the rebuilt urgent queue back
        logic nstep;       // process one normal entry
        logic ncommit;     // write back the normal count
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic scan_done;
    } dp_stat_t;

endpackage

// ===== rtl/tlatq_if.sv =====
// ----------------------------------------------------------------------------
// tlatq_if: valid/ready channel
// Generic channel carrying a payload of type PAYLOAD_T with valid and ready.
// ----------------------------------------------------------------------------
interface tlatq_if #(
    parameter type PAYLOAD_T = logic
);
    logic valid;
    logic ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tlatq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlatq_ctrl: sequencing controller
// Walks each request through decode, the aging passes and the result stage.
// ----------------------------------------------------------------------------
module tlatq_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic res_load,
    input  logic res_free,
    input  tlatq_pkg::dp_stat_t stat,
    output tlatq_pkg::dp_cmd_t cmd
);
    import tlatq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.scan_start = 1'b1;
                if (stat.kind == KIND_TICK_URGENT)
                begin
                    cmd.age_urgent = 1'b1;
                    state_next = ST_UAGE;
                end
                else if (stat.kind == KIND_TICK_NORMAL)
                begin
                    cmd.age_normal = 1'b1;
                    state_next = ST_NSCAN;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_UAGE:
            begin
                cmd.scan_start = 1'b1;
                state_next = ST_UEXP;
            end
            ST_UEXP:
            begin
                if (stat.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = ST_UKEEP;
                end
                else
                begin
                    cmd.uexp_step = 1'b1;
                end
            end
            ST_UKEEP:
            begin
                if (stat.scan_done)
                begin
                    cmd.ucommit = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.ukeep_step = 1'b1;
                end
            end
            ST_NSCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.ncommit = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.nstep = 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (res_free)
                begin
                    cmd.do_simple = 1'b1;
                    res_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/tlatq_dp.sv =====
// ----------------------------------------------------------------------------
// tlatq_dp: queue datapath
// Holds both queues in registers, the quanta, the scan index and the result
// fields. Ticks work one entry per cycle under controller command.
// ----------------------------------------------------------------------------
module tlatq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS = 6
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [tlatq_pkg::KIND_BITS-1:0] kind,
    input  logic [ID_BITS-1:0] task_id,
    input  logic cfg_we,
    input  logic [tlatq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tlatq_pkg::TIMER_BITS-1:0] cfg_data,
    input  tlatq_pkg::dp_cmd_t cmd,
    output tlatq_pkg::dp_stat_t stat,
    output logic [tlatq_pkg::STATUS_BITS-1:0] res_status,
    output logic res_task_valid,
    output logic [ID_BITS-1:0] res_task_out
);
    import tlatq_pkg::*;

    localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(QUEUE_DEPTH);

    logic [ID_BITS-1:0] uid_reg [QUEUE_DEPTH];
    logic [TIMER_BITS-1:0] utm_reg [QUEUE_DEPTH];
    logic [ID_BITS-1:0] nid_reg [QUEUE_DEPTH];
    logic [TIMER_BITS-1:0] ntm_reg [QUEUE_DEPTH];
    logic [ID_BITS-1:0] bid_reg [QUEUE_DEPTH];
    logic [TIMER_BITS-1:0] btm_reg [QUEUE_DEPTH];
    logic [CNT_BITS-1:0] ucnt_reg;
    logic [CNT_BITS-1:0] ncnt_reg;
    logic [CNT_BITS-1:0] scan_reg;
    logic [CNT_BITS-1:0] build_reg;
    logic [CNT_BITS-1:0] span_reg;
    logic [TIMER_BITS-1:0] uq_reg;
    logic [TIMER_BITS-1:0] nq_reg;
    logic [KIND_BITS-1:0] kind_reg;
    logic [ID_BITS-1:0] id_reg;

    logic [IDX_BITS-1:0] scan_idx;
    logic [IDX_BITS-1:0] rscan_idx;
    logic [IDX_BITS-1:0] build_idx;
    logic [IDX_BITS-1:0] ucnt_idx;
    logic [IDX_BITS-1:0] ncnt_idx;
    logic [CNT_BITS-1:0] rscan;
    logic promote;

    assign rscan = span_reg - scan_reg - CNT_BITS'(1);
    assign scan_idx = scan_reg[IDX_BITS-1:0];
    assign rscan_idx = rscan[IDX_BITS-1:0];
    assign build_idx = build_reg[IDX_BITS-1:0];
    assign ucnt_idx = ucnt_reg[IDX_BITS-1:0];
    assign ncnt_idx = ncnt_reg[IDX_BITS-1:0];
    assign promote = (ntm_reg[scan_idx] == '0) && (ucnt_reg != FULL);

    assign stat.kind = kind_reg;
    assign stat.scan_done = (scan_reg == span_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ucnt_reg <= '0;
            ncnt_reg <= '0;
            uq_reg <= URGENT_QUANTUM_RESET;
            nq_reg <= NORMAL_QUANTUM_RESET;
            kind_reg <= '0;
            scan_reg <= '0;
            build_reg <= '0;
            span_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_URGENT_QUANTUM: uq_reg <= cfg_data;
                    CFG_NORMAL_QUANTUM: nq_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                kind_reg <= kind;
            end
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
                span_reg <= (kind_reg == KIND_TICK_NORMAL) ? ncnt_reg : ucnt_reg;
                if (cmd.age_urgent || cmd.age_normal)
                begin
                    build_reg <= '0;
                end
            end
            if (cmd.uexp_step || cmd.ukeep_step || cmd.nstep)
            begin
                scan_reg <= scan_reg + CNT_BITS'(1);
            end
            if (cmd.uexp_step && utm_reg[rscan_idx] == '0)
            begin
                build_reg <= build_reg + CNT_BITS'(1);
            end
            if (cmd.ukeep_step && utm_reg[scan_idx] != '0)
            begin
                build_reg <= build_reg + CNT_BITS'(1);
            end
            if (cmd.nstep)
            begin
                if (promote)
                begin
                    ucnt_reg <= ucnt_reg + CNT_BITS'(1);
                end
                else
                begin
                    build_reg <= build_reg + CNT_BITS'(1);
                end
            end
            if (cmd.ncommit)
            begin
                ncnt_reg <= build_reg;
            end
            if (cmd.do_simple)
            begin
                unique case (kind_reg)
                    KIND_ENQ_URGENT:
                    begin
                        if (ucnt_reg != FULL)
                        begin
                            ucnt_reg <= ucnt_reg + CNT_BITS'(1);
                        end
                    end
                    KIND_ENQ_NORMAL:
                    begin
                        if (ncnt_reg != FULL)
                        begin
                            ncnt_reg <= ncnt_reg + CNT_BITS'(1);
                        end
                    end
                    KIND_DEQUEUE:
                    begin
                        if (ucnt_reg != '0)
                        begin
                            ucnt_reg <= ucnt_reg - CNT_BITS'(1);
                        end
                        else if (ncnt_reg != '0)
                        begin
                            ncnt_reg <= ncnt_reg - CNT_BITS'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg <= task_id;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cmd.age_urgent && CNT_BITS'(i) < ucnt_reg && utm_reg[i] != '0)
            begin
                utm_reg[i] <= utm_reg[i] - TIMER_BITS'(1);
            end
            if (cmd.age_normal && CNT_BITS'(i) < ncnt_reg && ntm_reg[i] != '0)
            begin
                ntm_reg[i] <= ntm_reg[i] - TIMER_BITS'(1);
            end
            if (cmd.ucommit)
            begin
                uid_reg[i] <= bid_reg[i];
                utm_reg[i] <= btm_reg[i];
            end
        end
        if (cmd.uexp_step && utm_reg[rscan_idx] == '0)
        begin
            bid_reg[build_idx] <= uid_reg[rscan_idx];
            btm_reg[build_idx] <= '0;
        end
        if (cmd.ukeep_step && utm_reg[scan_idx] != '0)
        begin
            bid_reg[build_idx] <= uid_reg[scan_idx];
            btm_reg[build_idx] <= utm_reg[scan_idx];
        end
        if (cmd.nstep)
        begin
            if (promote)
            begin
                uid_reg[ucnt_idx] <= nid_reg[scan_idx];
                utm_reg[ucnt_idx] <= uq_reg;
            end
            else
            begin
                nid_reg[build_idx] <= nid_reg[scan_idx];
                ntm_reg[build_idx] <= ntm_reg[scan_idx];
            end
        end
        if (cmd.do_simple)
        begin
            res_status <= STATUS_OK;
            res_task_valid <= 1'b0;
            res_task_out <= '0;
            unique case (kind_reg)
                KIND_ENQ_URGENT:
                begin
                    if (ucnt_reg != FULL)
                    begin
                        uid_reg[ucnt_idx] <= id_reg;
                        utm_reg[ucnt_idx] <= uq_reg;
                    end
                    else
                    begin
                        res_status <= STATUS_FULL;
                    end
                end
                KIND_ENQ_NORMAL:
                begin
                    if (ncnt_reg != FULL)
                    begin
                        nid_reg[ncnt_idx] <= id_reg;
                        ntm_reg[ncnt_idx] <= nq_reg;
                    end
                    else
                    begin
                        res_status <= STATUS_FULL;
                    end
                end
                KIND_DEQUEUE:
                begin
                    if (ucnt_reg != '0)
                    begin
                        res_task_valid <= 1'b1;
                        res_task_out <= uid_reg[0];
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                        begin
                            uid_reg[i] <= uid_reg[i+1];
                            utm_reg[i] <= utm_reg[i+1];
                        end
                    end
                    else if (ncnt_reg != '0)
                    begin
                        res_task_valid <= 1'b1;
                        res_task_out <= nid_reg[0];
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                        begin
                            nid_reg[i] <= nid_reg[i+1];
                            ntm_reg[i] <= ntm_reg[i+1];
                        end
                    end
                    else
                    begin
                        res_status <= STATUS_EMPTY;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/two_level_aging_task_queue_unit.sv =====
// ----------------------------------------------------------------------------
// two_level_aging_task_queue_unit: urgent and normal task queues with aging
// An enqueue, dequeue or no operation goes from decode to the result stage;
// an urgent tick over N entries ages them and makes two passes (one gathering
// expired entries from the tail, one gathering live ones from the head), a
// normal tick one pass, one entry per cycle. The result stage waits while the
// prior result sits in the output register. Requests are taken one at a time.
// ----------------------------------------------------------------------------
module two_level_aging_task_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS = 6
) (
    input logic clk,
    input logic rst_n,
    tlatq_if.sink req,
    tlatq_if.source rsp,
    tlatq_if.sink cfg
);
    import tlatq_pkg::*;

    dp_cmd_t cmd;
    dp_stat_t stat;
    logic res_load;
    logic rsp_valid_reg;
    logic [STATUS_BITS-1:0] res_status;
    logic res_task_valid;
    logic [ID_BITS-1:0] res_task_out;

    assign cfg.ready = 1'b1;

    tlatq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .res_load (res_load),
        .res_free (!rsp_valid_reg || rsp.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tlatq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .kind           (req.data.kind),
        .task_id        (req.data.task_id),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.data.index[CFG_INDEX_BITS-1:0]),
        .cfg_data       (cfg.data.value),
        .cmd            (cmd),
        .stat           (stat),
        .res_status     (res_status),
        .res_task_valid (res_task_valid),
        .res_task_out   (res_task_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data.status = res_status;
    assign rsp.data.task_valid = res_task_valid;
    assign rsp.data.task_out = res_task_out;
endmodule

// ===== rtl/tlatq_checker.sv =====
// ----------------------------------------------------------------------------
// tlatq_checker: port-level checks
// Watches the request and result channels of the task queue unit.
// ----------------------------------------------------------------------------
module tlatq_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [1:0] rsp_status,
    input logic rsp_task_valid
);
    import tlatq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");

    a_valid_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_task_valid |-> rsp_status == STATUS_OK)
        else $error("dequeued task with error status");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared too soon");
endmodule

bind two_level_aging_task_queue_unit tlatq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.data.status),
    .rsp_task_valid (rsp.data.task_valid)
);

// ===== test/tb_two_level_aging_task_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_two_level_aging_task_queue_unit: self-checking testbench
// Drives enqueue, tick and dequeue requests into the aging task queue under
// random idling on both sides. Every request is predicted by a local model of
// the urgent and normal queues. Each response is compared field by field in
// order. The queue quanta are rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_two_level_aging_task_queue_unit;
    import tlatq_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDW = 6;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [IDW-1:0] task_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic task_valid;
        logic [IDW-1:0] task_out;
    } rsp_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [TIMER_BITS-1:0] value;
    } cfg_t;

    logic clk;
    logic rst_n;

    tlatq_if #(.PAYLOAD_T(req_t)) req_ch ();
    tlatq_if #(.PAYLOAD_T(rsp_t)) rsp_ch ();
    tlatq_if #(.PAYLOAD_T(cfg_t)) cfg_ch ();

    two_level_aging_task_queue_unit #(
        .QUEUE_DEPTH(DEPTH),
        .ID_BITS(IDW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch.sink),
        .rsp(rsp_ch.source),
        .cfg(cfg_ch.sink)
    );

    // Local copy of both queues and the quanta.
    logic [IDW-1:0] urg_id [DEPTH];
    logic [TIMER_BITS-1:0] urg_tmr [DEPTH];
    int urg_cnt;
    logic [IDW-1:0] nrm_id [DEPTH];
    logic [TIMER_BITS-1:0] nrm_tmr [DEPTH];
    int nrm_cnt;
    logic [TIMER_BITS-1:0] urg_quantum;
    logic [TIMER_BITS-1:0] nrm_quantum;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    int errors;
    int accepted_reqs;
    int checked_rsps;
    int dequeued_tasks;
    int full_drops;
    int cycle_count;
    int src_gap;
    int sink_gap;
    int hold_left;
    int pause_mark;
    logic src_pause;
    logic quiet;

    function automatic rsp_t schedule_request(req_t r);
        rsp_t res;
        logic [IDW-1:0] ids [DEPTH];
        logic [TIMER_BITS-1:0] tms [DEPTH];
        int k;
        res = '0;
        case (r.kind)
            KIND_ENQ_URGENT:
                if (urg_cnt >= DEPTH) res.status = STATUS_FULL;
                else
                begin
                    urg_id[urg_cnt] = r.task_id;
                    urg_tmr[urg_cnt] = urg_quantum;
                    urg_cnt++;
                end
            KIND_ENQ_NORMAL:
                if (nrm_cnt >= DEPTH) res.status = STATUS_FULL;
                else
                begin
                    nrm_id[nrm_cnt] = r.task_id;
                    nrm_tmr[nrm_cnt] = nrm_quantum;
                    nrm_cnt++;
                end
            KIND_TICK_URGENT:
            begin
                k = 0;
                for (int i = 0; i < urg_cnt; i++)
                    if (urg_tmr[i] != 0) urg_tmr[i]--;
                for (int i = urg_cnt - 1; i >= 0; i--)
                    if (urg_tmr[i] == 0)
                    begin
                        ids[k] = urg_id[i];
                        tms[k] = '0;
                        k++;
                    end
                for (int i = 0; i < urg_cnt; i++)
                    if (urg_tmr[i] != 0)
                    begin
                        ids[k] = urg_id[i];
                        tms[k] = urg_tmr[i];
                        k++;
                    end
                for (int i = 0; i < k; i++)
                begin
                    urg_id[i] = ids[i];
                    urg_tmr[i] = tms[i];
                end
            end
            KIND_TICK_NORMAL:
            begin
                k = 0;
                for (int i = 0; i < nrm_cnt; i++)
                    if (nrm_tmr[i] != 0) nrm_tmr[i]--;
                for (int i = 0; i < nrm_cnt; i++)
                begin
                    if (nrm_tmr[i] == 0 && urg_cnt < DEPTH)
                    begin
                        urg_id[urg_cnt] = nrm_id[i];
                        urg_tmr[urg_cnt] = urg_quantum;
                        urg_cnt++;
                    end
                    else
                    begin
                        nrm_id[k] = nrm_id[i];
                        nrm_tmr[k] = nrm_tmr[i];
                        k++;
                    end
                end
                nrm_cnt = k;
            end
            KIND_DEQUEUE:
                if (urg_cnt > 0)
                begin
                    res.task_valid = 1'b1;
                    res.task_out = urg_id[0];
                    for (int i = 1; i < urg_cnt; i++)
                    begin
                        urg_id[i-1] = urg_id[i];
                        urg_tmr[i-1] = urg_tmr[i];
                    end
                    urg_cnt--;
                end
                else if (nrm_cnt > 0)
                begin
                    res.task_valid = 1'b1;
                    res.task_out = nrm_id[0];
                    for (int i = 1; i < nrm_cnt; i++)
                    begin
                        nrm_id[i-1] = nrm_id[i];
                        nrm_tmr[i-1] = nrm_tmr[i];
                    end
                    nrm_cnt--;
                end
                else res.status = STATUS_EMPTY;
            default: ;
        endcase
        return res;
    endfunction

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk or negedge rst_n)
    begin
        req_t nxt;
        logic offer;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsps.push_back(schedule_request(req_ch.data));
                accepted_reqs++;
            end
            offer = req_ch.valid && !req_ch.ready;
            if (!offer)
            begin
                if (src_gap > 0) src_gap--;
                else if (!src_pause && pending_reqs.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 4);
                    else
                    begin
                        nxt = pending_reqs.pop_front();
                        req_ch.data <= nxt;
                        offer = 1'b1;
                    end
                end
            end
            req_ch.valid <= offer;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        logic rdy;
        if (!rst_n) rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response %p", $time, rsp_ch.data);
                    errors++;
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    checked_rsps++;
                    if (rsp_ch.data.task_valid) dequeued_tasks++;
                    if (rsp_ch.data.status == STATUS_FULL) full_drops++;
                    if (rsp_ch.data.status !== exp_rsp.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_rsp.status, rsp_ch.data.status);
                        errors++;
                    end
                    if (rsp_ch.data.task_valid !== exp_rsp.task_valid)
                    begin
                        $display("%0t: task_valid expected %0d actual %0d", $time,
                                 exp_rsp.task_valid, rsp_ch.data.task_valid);
                        errors++;
                    end
                    if (rsp_ch.data.task_out !== exp_rsp.task_out)
                    begin
                        $display("%0t: task_out expected %0d actual %0d", $time,
                                 exp_rsp.task_out, rsp_ch.data.task_out);
                        errors++;
                    end
                end
            end
            rdy = 1'b1;
            if (hold_left > 0) rdy = 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                rdy = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 3);
                rdy = 1'b0;
            end
            rsp_ch.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding", $time,
                     expected_rsps.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_req(logic [KIND_BITS-1:0] kind, logic [IDW-1:0] id);
        req_t r;
        r.kind = kind;
        r.task_id = id;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_quantum(logic [CFG_INDEX_BITS-1:0] idx,
                                 logic [TIMER_BITS-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, value: value};
        do @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_URGENT_QUANTUM) urg_quantum = value;
        else nrm_quantum = value;
    endtask

    task automatic add_random(int count);
        int w;
        for (int n = 0; n < count; n++)
        begin
            w = $urandom_range(0, 99);
            if (w < 3) add_req(KIND_BITS'($urandom_range(5, 7)), IDW'($urandom));
            else if (w < 5)
                for (int j = 0; j < 18; j++)
                    add_req(j[0] ? KIND_ENQ_NORMAL : KIND_ENQ_URGENT, IDW'($urandom));
            else if (w < 28) add_req(KIND_ENQ_URGENT, IDW'($urandom));
            else if (w < 50) add_req(KIND_ENQ_NORMAL, IDW'($urandom));
            else if (w < 64) add_req(KIND_TICK_URGENT, IDW'($urandom));
            else if (w < 80) add_req(KIND_TICK_NORMAL, IDW'($urandom));
            else add_req(KIND_DEQUEUE, IDW'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        accepted_reqs = 0;
        checked_rsps = 0;
        dequeued_tasks = 0;
        full_drops = 0;
        cycle_count = 0;
        src_gap = 0;
        sink_gap = 0;
        hold_left = 0;
        pause_mark = 0;
        src_pause = 1'b0;
        quiet = 1'b0;
        urg_cnt = 0;
        nrm_cnt = 0;
        urg_quantum = URGENT_QUANTUM_RESET;
        nrm_quantum = NORMAL_QUANTUM_RESET;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        add_req(KIND_DEQUEUE, 6'd63);
        add_req(3'd5, 6'd63);
        add_req(3'd7, 6'd42);
        add_req(KIND_ENQ_URGENT, 6'd63);
        add_req(KIND_ENQ_URGENT, 6'd0);
        add_req(KIND_ENQ_NORMAL, 6'd63);
        add_req(KIND_ENQ_NORMAL, 6'd21);
        add_req(KIND_TICK_URGENT, 6'd0);
        add_req(KIND_TICK_URGENT, 6'd0);
        add_req(KIND_ENQ_URGENT, 6'd5);
        add_req(KIND_TICK_URGENT, 6'd63);
        add_req(KIND_TICK_URGENT, 6'd0);
        add_req(KIND_TICK_NORMAL, 6'd0);
        add_req(KIND_DEQUEUE, 6'd0);
        add_req(KIND_DEQUEUE, 6'd0);
        add_req(KIND_DEQUEUE, 6'd0);
        add_req(KIND_DEQUEUE, 6'd0);
        add_req(KIND_DEQUEUE, 6'd0);
        add_req(KIND_DEQUEUE, 6'd0);
        drain();

        write_quantum(CFG_URGENT_QUANTUM, 4'd1);
        write_quantum(CFG_NORMAL_QUANTUM, 4'd1);
        hold_left = 80;
        add_random(160);
        drain();

        write_quantum(CFG_URGENT_QUANTUM, 4'd15);
        write_quantum(CFG_NORMAL_QUANTUM, 4'd15);
        add_random(80);
        pause_mark = accepted_reqs + 40;
        while (pending_reqs.size() != 0 && accepted_reqs < pause_mark) @(negedge clk);
        src_pause = 1'b1;
        while (req_ch.valid || expected_rsps.size() != 0) @(negedge clk);
        src_pause = 1'b0;
        drain();

        write_quantum(CFG_URGENT_QUANTUM, 4'd2);
        write_quantum(CFG_NORMAL_QUANTUM, 4'd4);
        add_random(200);
        drain();

        write_quantum(CFG_URGENT_QUANTUM, 4'd5);
        write_quantum(CFG_NORMAL_QUANTUM, 4'd2);
        add_random(120);
        drain();

        quiet = 1'b1;
        add_random(100);
        drain();

        $display("%0d requests, %0d responses checked, %0d tasks dequeued, %0d full drops",
                 accepted_reqs, checked_rsps, dequeued_tasks, full_drops);
        $display("quanta swept from 1 to 15 with long response stall and sender pause");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
